[rtl/core/mctl_pkg.sv]
// Shared types and constants for the top-k log-loss core.
// No dependencies.
package mctl_pkg;
    localparam int MaxPredictorsDefault = 8;
    localparam int ProbFloorDefault = 1;
    localparam int Depth = 8;
    localparam logic [15:0] Ln2Q16 = 16'd45426;
    localparam logic [3:0] MantissaMsb = 4'd15;

    typedef enum logic [0:0]
    {
        REG_PREDICTORS = 1'b0,
        REG_PICKS = 1'b1
    } reg_index_t;

    typedef enum logic [0:0]
    {
        REQ_PROB = 1'b0,
        REQ_BATCH = 1'b1
    } req_t;

    typedef struct packed
    {
        logic       batch;
        logic [2:0] idx;
        logic [15:0] loss;
        logic       last_in_sample;
    } job_t;

    typedef enum logic [2:0]
    {
        BK_IDLE,
        BK_SEL,
        BK_ACC,
        BK_DIV,
        BK_OUT
    } bk_state_t;

    typedef enum logic [1:0]
    {
        FR_IDLE,
        FR_SQR,
        FR_SCALE,
        FR_PUSH
    } fr_state_t;

    typedef struct packed
    {
        logic       kind;
        logic [2:0] who;
        logic [2:0] rank;
        logic [15:0] loss;
        logic       last;
    } result_t;
endpackage

[rtl/core/mctl_front.sv]
// Front end: accepts items and turns each probability into -ln(p) in Q4.12
// by iterative squaring. Depends on mctl_pkg.
module mctl_front
    import mctl_pkg::*;
#(
    parameter int PROB_FLOOR = ProbFloorDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [2:0]  pred_index,
    input  logic [15:0] prob,
    input  logic        last_in_sample,
    output logic        job_valid,
    input  logic        job_stall,
    output job_t        job
);
    fr_state_t   state_reg, state_next;
    logic [16:0] x_reg, x_next;
    logic [15:0] f_reg, f_next;
    logic [3:0]  e_reg, e_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [20:0] l2_reg, l2_next;
    job_t        job_reg, job_next;
    logic [15:0] p;
    logic [3:0]  e;
    logic [33:0] sq;
    logic [16:0] xs;
    logic [37:0] prod;

    always_comb
    begin
        p = (prob < 16'(PROB_FLOOR)) ? 16'(PROB_FLOOR) : prob;
        if (p == 16'd0)
        begin
            p = 16'd1;
        end
        e = 4'd0;
        for (int i = 1; i < 16; i++)
        begin
            if (p[i])
            begin
                e = 4'(i);
            end
        end
        sq = 34'(x_reg) * 34'(x_reg);
        xs = sq[31:15];
        prod = 38'(l2_reg) * 38'(Ln2Q16) + 38'(1 << 19);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        f_reg <= f_next;
        e_reg <= e_next;
        cnt_reg <= cnt_next;
        l2_reg <= l2_next;
        job_reg <= job_next;
    end

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg;
        f_next = f_reg;
        e_next = e_reg;
        cnt_next = cnt_reg;
        l2_next = l2_reg;
        job_next = job_reg;
        in_stall = 1'b1;
        job_valid = 1'b0;
        case (state_reg)
            FR_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    job_next.batch = req_type;
                    job_next.idx = pred_index;
                    job_next.last_in_sample = last_in_sample;
                    job_next.loss = 16'd0;
                    x_next = 17'((32'(p) << (MantissaMsb - e)));
                    e_next = e;
                    f_next = 16'd0;
                    cnt_next = 4'd0;
                    state_next = (req_type == REQ_BATCH) ? FR_PUSH : FR_SQR;
                end
            end
            FR_SQR:
            begin
                f_next = {f_reg[14:0], xs[16]};
                x_next = xs[16] ? {1'b0, xs[16:1]} : xs;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    l2_next = 21'((32'd16 << 16) - ((32'(e_reg) << 16) + 32'(f_next)));
                    state_next = FR_SCALE;
                end
            end
            FR_SCALE:
            begin
                job_next.loss = prod[35:20];
                state_next = FR_PUSH;
            end
            FR_PUSH:
            begin
                job_valid = 1'b1;
                if (!job_stall)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    assign job = job_reg;
endmodule

[rtl/core/mctl_queue.sv]
// Two-entry queue between front and back ends. Depends on mctl_pkg.
module mctl_queue
    import mctl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_stall,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr = wr_valid && !wr_stall;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

[rtl/core/mctl_back.sv]
// Back end: stores losses, selects picks one rank per pass, accumulates,
// and divides for batch reports. Depends on mctl_pkg.
module mctl_back
    import mctl_pkg::*;
#(
    parameter int MAX_PREDICTORS = MaxPredictorsDefault
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [3:0] cfg_data,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job,
    output logic       out_valid,
    input  logic       out_stall,
    output result_t    res,
    output logic       busy
);
    localparam int Lim = (MAX_PREDICTORS < Depth) ? MAX_PREDICTORS : Depth;

    bk_state_t   state_reg, state_next;
    logic [3:0]  npr_reg, pick_reg;
    logic [15:0] sl_reg [Depth];
    logic [31:0] sum_reg [Depth];
    logic [15:0] cnt_reg [Depth];
    logic [Depth-1:0] taken_reg, taken_next;
    logic [3:0]  scan_reg, scan_next;
    logic [3:0]  best_reg, best_next;
    logic [2:0]  rank_reg, rank_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [5:0]  bit_reg, bit_next;
    result_t     res_reg, res_next;
    logic        do_acc, do_clear;
    logic [3:0]  np, k;
    logic [32:0] trial;
    logic [32:0] ssum;

    always_comb
    begin
        np = npr_reg;
        if (np < 4'd2)
        begin
            np = 4'd2;
        end
        if (np > 4'(Lim))
        begin
            np = 4'(Lim);
        end
        k = pick_reg;
        if (k < 4'd1)
        begin
            k = 4'd1;
        end
        if (k > np)
        begin
            k = np;
        end
        trial = {rem_reg, quo_reg[31]} - 33'(cnt_reg[scan_reg[2:0]]);
        ssum = 33'(sum_reg[best_reg[2:0]]) + 33'(sl_reg[best_reg[2:0]]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            npr_reg <= 4'd8;
            pick_reg <= 4'd1;
            for (int i = 0; i < Depth; i++)
            begin
                sum_reg[i] <= 32'd0;
                cnt_reg[i] <= 16'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_PREDICTORS)
                begin
                    npr_reg <= cfg_data;
                end
                else
                begin
                    pick_reg <= cfg_data;
                end
            end
            if (do_acc)
            begin
                sum_reg[best_reg[2:0]] <= ssum[32] ? 32'hFFFFFFFF : ssum[31:0];
                if (cnt_reg[best_reg[2:0]] != 16'hFFFF)
                begin
                    cnt_reg[best_reg[2:0]] <= cnt_reg[best_reg[2:0]] + 16'd1;
                end
            end
            if (do_clear)
            begin
                for (int i = 0; i < Depth; i++)
                begin
                    sum_reg[i] <= 32'd0;
                    cnt_reg[i] <= 16'd0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && job_valid && !job.batch)
        begin
            sl_reg[job.idx] <= job.loss;
        end
        taken_reg <= taken_next;
        scan_reg <= scan_next;
        best_reg <= best_next;
        rank_reg <= rank_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        bit_reg <= bit_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        taken_next = taken_reg;
        scan_next = scan_reg;
        best_next = best_reg;
        rank_next = rank_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        bit_next = bit_reg;
        res_next = res_reg;
        job_ready = 1'b0;
        out_valid = 1'b0;
        do_acc = 1'b0;
        do_clear = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    taken_next = '0;
                    rank_next = 3'd0;
                    scan_next = 4'd0;
                    best_next = 4'(Depth);
                    if (job.batch)
                    begin
                        rem_next = 32'd0;
                        quo_next = sum_reg[0];
                        bit_next = 6'd0;
                        state_next = BK_DIV;
                    end
                    else if (job.last_in_sample)
                    begin
                        state_next = BK_SEL;
                    end
                end
            end
            BK_SEL:
            begin
                if (!taken_reg[scan_reg[2:0]] &&
                    (best_reg == 4'(Depth) ||
                     sl_reg[scan_reg[2:0]] < sl_reg[best_reg[2:0]]))
                begin
                    best_next = scan_reg;
                end
                scan_next = scan_reg + 4'd1;
                if (scan_reg + 4'd1 == np)
                begin
                    state_next = BK_ACC;
                end
            end
            BK_ACC:
            begin
                do_acc = 1'b1;
                taken_next[best_reg[2:0]] = 1'b1;
                res_next.kind = 1'b0;
                res_next.who = best_reg[2:0];
                res_next.rank = rank_reg;
                res_next.loss = sl_reg[best_reg[2:0]];
                res_next.last = (4'(rank_reg) + 4'd1 == k);
                state_next = BK_OUT;
            end
            BK_DIV:
            begin
                if (cnt_reg[scan_reg[2:0]] == 16'd0)
                begin
                    quo_next = 32'd0;
                    bit_next = 6'd32;
                end
                else if (!trial[32])
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                    bit_next = bit_reg + 6'd1;
                end
                else
                begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                    bit_next = bit_reg + 6'd1;
                end
                if (bit_next == 6'd32)
                begin
                    res_next.kind = 1'b1;
                    res_next.who = scan_reg[2:0];
                    res_next.rank = 3'd0;
                    res_next.loss = (quo_next[31:16] != 16'd0) ? 16'hFFFF : quo_next[15:0];
                    res_next.last = (scan_reg + 4'd1 == np);
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (res_reg.kind)
                    begin
                        if (res_reg.last)
                        begin
                            do_clear = 1'b1;
                            state_next = BK_IDLE;
                        end
                        else
                        begin
                            scan_next = scan_reg + 4'd1;
                            rem_next = 32'd0;
                            quo_next = sum_reg[3'(scan_reg + 4'd1)];
                            bit_next = 6'd0;
                            state_next = BK_DIV;
                        end
                    end
                    else if (res_reg.last)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        rank_next = rank_reg + 3'd1;
                        scan_next = 4'd0;
                        best_next = 4'(Depth);
                        state_next = BK_SEL;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign res = res_reg;
    assign busy = (state_reg != BK_IDLE);
endmodule

[rtl/core/multiple_choice_topk_log_loss_core.sv]
// Top level of the top-k log-loss core: front end, queue and back end.
// Depends on mctl_pkg, mctl_front, mctl_queue and mctl_back.
//
// Input channel (in_valid/in_stall) takes one beat per predictor probability
// or one end-of-batch beat. Output channel (out_valid/out_stall) gives
// assignment and mean-loss beats, with last on the final beat of a run.
// Configuration is a write port: cfg_we, cfg_index, cfg_data.
// In the front end a probability beat runs the 16-step squaring logarithm,
// one bit per cycle, then a scaling step and the handoff.
// At the end of a sample the back end scans P losses for each of the k
// picks. A batch report runs a 32-step radix-2 divider per predictor,
// skipped for a predictor with no picks, to give each report beat.
// The two-entry queue lets the front end work on the next beat while the
// back end selects or waits on a stalled output.
// Reset clears sums, counts and registers to their reset values; sample
// losses are undefined until written. A stalled output holds its beat and
// back-pressure reaches the input through the queue.
module multiple_choice_topk_log_loss_core
    import mctl_pkg::*;
#(
    parameter int MAX_PREDICTORS = MaxPredictorsDefault,
    parameter int PROB_FLOOR = ProbFloorDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [2:0]  pred_index,
    input  logic [15:0] prob,
    input  logic        last_in_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [2:0]  chosen_predictor,
    output logic [2:0]  rank,
    output logic [15:0] mean_loss,
    output logic        last
);
    logic    fj_valid, fj_stall, qj_valid, qj_ready, busy;
    job_t    fj, qj;
    result_t res;

    mctl_front #(.PROB_FLOOR(PROB_FLOOR)) u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .pred_index(pred_index), .prob(prob),
        .last_in_sample(last_in_sample), .job_valid(fj_valid),
        .job_stall(fj_stall), .job(fj)
    );

    mctl_queue u_queue
    (
        .clk(clk), .rst_n(rst_n), .wr_valid(fj_valid), .wr_stall(fj_stall),
        .wr_data(fj), .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_data(qj)
    );

    mctl_back #(.MAX_PREDICTORS(MAX_PREDICTORS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .job_valid(qj_valid), .job_ready(qj_ready),
        .job(qj), .out_valid(out_valid), .out_stall(out_stall), .res(res),
        .busy(busy)
    );

    assign kind = res.kind;
    assign chosen_predictor = res.who;
    assign rank = res.rank;
    assign mean_loss = res.loss;
    assign last = res.last;

    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("output beat without back-end activity");
    a_assign_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind) |-> (mean_loss <= 16'd45426))
        else $error("assignment loss out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(mean_loss)))
        else $error("stalled result changed");
endmodule

[tb/mctl_checker.sv]
// Checker for multiple_choice_topk_log_loss_core: watches config writes and both channels,
// predicts the result beats and compares them field by field. Depends on mctl_pkg.
module mctl_checker
    import mctl_pkg::*;
#(
    parameter int MAX_PREDICTORS = 8,
    parameter int PROB_FLOOR = 1
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [2:0]  pred_index,
    input  logic [15:0] prob,
    input  logic        last_in_sample,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        kind,
    input  logic [2:0]  chosen_predictor,
    input  logic [2:0]  rank,
    input  logic [15:0] mean_loss,
    input  logic        last,
    output int          fails,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_MEAN = 1'b1;

    logic [3:0]  np_reg;
    logic [3:0]  k_reg;
    logic [15:0] latest_loss [Depth];
    logic [31:0] loss_total [Depth];
    logic [15:0] pick_total [Depth];
    result_t     awaited [$];

    assign pending = awaited.size();

    function automatic logic [15:0] prob_to_loss(logic [15:0] pr);
        logic [31:0] p;
        logic [63:0] x;
        logic [63:0] l2;
        logic [31:0] e;
        logic [31:0] f;
        p = (pr < PROB_FLOOR) ? PROB_FLOOR : pr;
        if (p == 0) p = 1;
        if (p > 32'hFFFF) p = 32'hFFFF;
        e = 0;
        f = 0;
        while (e < 15 && (p >> (e + 1)) != 0) e++;
        x = 64'(p) << (15 - e);
        for (int i = 0; i < 16; i++)
        begin
            x = (x * x) >> 15;
            f = f << 1;
            if (x >= 64'd65536)
            begin
                f = f | 1;
                x = x >> 1;
            end
        end
        l2 = (64'd16 << 16) - ((64'(e) << 16) + 64'(f));
        return 16'((l2 * 64'(Ln2Q16) + 64'd524288) >> 20);
    endfunction

    function automatic int unsigned active_predictors();
        int unsigned lim;
        int unsigned p;
        lim = (MAX_PREDICTORS < Depth) ? MAX_PREDICTORS : Depth;
        p = np_reg;
        if (p < 2) p = 2;
        if (p > lim) p = lim;
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned np;
        int unsigned k;
        int unsigned best;
        int unsigned mean;
        bit          taken [Depth];
        result_t     r;
        if (!rst_n)
        begin
            np_reg <= 4'd8;
            k_reg <= 4'd1;
            for (int i = 0; i < Depth; i++)
            begin
                loss_total[i] = '0;
                pick_total[i] = '0;
                latest_loss[i] = '0;
            end
            awaited.delete();
            fails <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PREDICTORS) np_reg <= cfg_data;
                else k_reg <= cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                np = active_predictors();
                if (req_type == REQ_BATCH)
                begin
                    for (int i = 0; i < np; i++)
                    begin
                        mean = 0;
                        if (pick_total[i] != 0)
                        begin
                            mean = loss_total[i] / pick_total[i];
                            if (mean > 32'hFFFF) mean = 32'hFFFF;
                        end
                        r = '{KIND_MEAN, 3'(i), 3'd0, 16'(mean), (i + 1 == np)};
                        awaited.insert(awaited.size(), r);
                    end
                    for (int i = 0; i < Depth; i++)
                    begin
                        loss_total[i] = '0;
                        pick_total[i] = '0;
                    end
                end
                else
                begin
                    latest_loss[pred_index] = prob_to_loss(prob);
                    if (last_in_sample)
                    begin
                        k = k_reg;
                        if (k < 1) k = 1;
                        if (k > np) k = np;
                        for (int i = 0; i < Depth; i++) taken[i] = 0;
                        for (int q = 0; q < k; q++)
                        begin
                            best = Depth;
                            for (int i = 0; i < np; i++)
                                if (!taken[i] && (best == Depth
                                    || latest_loss[i] < latest_loss[best]))
                                    best = i;
                            taken[best] = 1;
                            if (loss_total[best] > 32'hFFFFFFFF - latest_loss[best])
                                loss_total[best] = 32'hFFFFFFFF;
                            else
                                loss_total[best] = loss_total[best] + latest_loss[best];
                            if (pick_total[best] != 16'hFFFF)
                                pick_total[best] = pick_total[best] + 1;
                            r = '{KIND_ASSIGN, 3'(best), 3'(q), latest_loss[best],
                                  (q + 1 == k)};
                            awaited.insert(awaited.size(), r);
                        end
                    end
                end
            end
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    if (fails < 10)
                        $display("%0t unexpected beat: kind=%0d who=%0d rank=%0d loss=%0d last=%0d",
                                 $realtime, kind, chosen_predictor, rank, mean_loss, last);
                    fails <= fails + 1;
                end
                else
                begin
                    r = awaited.pop_front();
                    if (r.kind !== kind || r.who !== chosen_predictor || r.rank !== rank
                        || r.loss !== mean_loss || r.last !== last)
                    begin
                        if (fails < 10)
                            $display("%0t mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                     $realtime, r.kind, r.who, r.rank, r.loss, r.last,
                                     kind, chosen_predictor, rank, mean_loss, last);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/tb.sv]
// Top of the testbench for multiple_choice_topk_log_loss_core: clock, reset, stimulus
// and verdict. Depends on mctl_pkg, the core and mctl_checker.
module tb
    import mctl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [3:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [2:0]  pred_index;
    logic [15:0] prob;
    logic        last_in_sample;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [2:0]  chosen_predictor;
    logic [2:0]  rank;
    logic [15:0] mean_loss;
    logic        last;
    int          fails;
    int          pending;
    bit          calm;
    int          sent;
    int          active_np;

    multiple_choice_topk_log_loss_core dut (.*);
    mctl_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 9);

    initial
    begin
        #50ms;
        $display("multiple_choice_topk_log_loss_core test failed");
        $finish;
    end

    task automatic push_beat(req_t rt, logic [2:0] idx, logic [15:0] pr, logic lst);
        if (!calm && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        pred_index <= idx;
        prob <= pr;
        last_in_sample <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_regs(logic [3:0] np, logic [3:0] k);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_PREDICTORS;
        cfg_data <= np;
        @(posedge clk);
        cfg_index <= REG_PICKS;
        cfg_data <= k;
        @(posedge clk);
        cfg_we <= 1'b0;
        active_np = (np < 2) ? 2 : (np > 8) ? 8 : np;
    endtask

    function automatic logic [15:0] pick_prob();
        case ($urandom_range(3))
            0: return 16'($urandom_range(0, 16));
            1: return 16'($urandom_range(65500, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_sample();
        int unsigned order [$];
        int unsigned j;
        int unsigned tmp;
        logic [15:0] shared;
        shared = pick_prob();
        for (int i = 0; i < active_np; i++) order.insert(order.size(), i);
        for (int i = active_np - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < active_np; i++)
        begin
            if (active_np < 8 && $urandom_range(9) == 0)
                push_beat(REQ_PROB, 3'($urandom_range(active_np, 7)), pick_prob(), 1'b0);
            push_beat(REQ_PROB, 3'(order[i]),
                      ($urandom_range(3) == 0) ? shared : pick_prob(),
                      i == active_np - 1);
        end
    endtask

    initial
    begin
        logic [3:0] np_list [6];
        logic [3:0] k_list [6];
        int         phase_start;
        logic [15:0] dir_probs [8];
        np_list = '{4'd0, 4'd15, 4'd5, 4'd8, 4'd3, 4'd7};
        k_list = '{4'd15, 4'd0, 4'd3, 4'd8, 4'd1, 4'd4};
        dir_probs = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'h8000, 16'hAAAA, 16'h5555, 16'd1000};
        calm = 1'b0;
        sent = 0;
        active_np = 8;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PREDICTORS;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_PROB;
        pred_index = '0;
        prob = '0;
        last_in_sample = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 8; i++)
            push_beat(REQ_PROB, 3'(i), dir_probs[i], i == 7);
        for (int i = 0; i < 8; i++)
            push_beat(REQ_PROB, 3'(i), 16'h4000, i == 7);
        push_beat(REQ_BATCH, 3'd7, 16'hFFFF, 1'b1);
        push_beat(REQ_BATCH, 3'd0, 16'd0, 1'b0);

        for (int ph = 0; ph < 6; ph++)
        begin
            write_regs(np_list[ph], k_list[ph]);
            calm = (ph == 3);
            phase_start = sent;
            while (sent - phase_start < 14)
            begin
                case ($urandom_range(9))
                    0: push_beat(REQ_PROB, 3'($urandom), pick_prob(), $urandom_range(1));
                    1: push_beat(REQ_BATCH, 3'($urandom), 16'($urandom), $urandom_range(1));
                    default: random_sample();
                endcase
                if (ph == 2 && sent - phase_start > 10)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
            end
            push_beat(REQ_BATCH, 3'd0, 16'd0, 1'b0);
        end
        calm = 1'b0;
        drain();

        if (fails == 0 && pending == 0)
            $display("multiple_choice_topk_log_loss_core test passed");
        else
            $display("multiple_choice_topk_log_loss_core test failed");
        $finish;
    end
endmodule
